// ===== rtl/core/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper: access kinds,
// target codes, variant codes, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package cbm_pkg;

    // Field widths
    localparam int MODE_W      = 2;
    localparam int BUS_ADDR_W  = 16;
    localparam int WDATA_W     = 8;
    localparam int TARGET_W    = 2;
    localparam int MEM_ADDR_W  = 19;
    localparam int VARIANT_W   = 2;
    localparam int SIZE_LOG2_W = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    // Bank register file
    localparam int BANK_REGS   = 8;
    localparam int BANK_IDX_W  = $clog2(BANK_REGS);
    localparam int BANK_W      = 6;
    localparam int SELECT_W    = 3;

    // Stream word widths (whole bytes)
    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 8;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 8;

    // Size limits of the roms
    localparam logic [SIZE_LOG2_W-1:0] PRG_LOG2_MIN   = 5'd14;
    localparam logic [SIZE_LOG2_W-1:0] PRG_LOG2_MAX   = 5'd19;
    localparam logic [SIZE_LOG2_W-1:0] PRG_LOG2_RESET = 5'd17;
    localparam logic [SIZE_LOG2_W-1:0] CHR_LOG2_MIN   = 5'd13;
    localparam logic [SIZE_LOG2_W-1:0] CHR_LOG2_MAX   = 5'd17;
    localparam logic [SIZE_LOG2_W-1:0] CHR_LOG2_RESET = 5'd17;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_PRG   = 2'd1,
        MODE_CHR   = 2'd2,
        MODE_NT    = 2'd3
    } mode_t;

    typedef enum logic [TARGET_W-1:0] {
        TGT_PRG = 2'd0,
        TGT_CHR = 2'd1,
        TGT_NT  = 2'd2
    } target_t;

    typedef enum logic [VARIANT_W-1:0] {
        VAR_BASE = 2'd0,
        VAR_A    = 2'd1,
        VAR_B    = 2'd2,
        VAR_C    = 2'd3
    } variant_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VARIANT  = 2'd0,
        CFG_PRG_SIZE = 2'd1,
        CFG_CHR_SIZE = 2'd2,
        CFG_UNUSED   = 2'd3
    } cfg_index_t;

    // Saturate a size exponent into its legal range
    function automatic logic [SIZE_LOG2_W-1:0] clamp_log2(
        input logic [SIZE_LOG2_W-1:0] v,
        input logic [SIZE_LOG2_W-1:0] lo,
        input logic [SIZE_LOG2_W-1:0] hi
    );
        logic [SIZE_LOG2_W-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/cartridge_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// Translates cpu/ppu bus accesses into program rom, character rom and
// nametable ram byte addresses through a bank register file.
// ----------------------------------------------------------------------------
// One bus access is taken every cycle while the result side keeps m_tready
// high; a stalled result word holds the input register and so the input.
// The input register holds the access while the bank lookup and window
// arithmetic run, and the result register takes the translated address
// once it can take a word. Register writes and nametable accesses in the
// base and A variants give no output word. Bank state changes when a write
// leaves the input register, so each access sees every earlier write.
// Configuration is to be written through the cfg port only while the block
// is idle; the block itself does not enforce this. The cfg port is always ready.
module cartridge_bank_mapper (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]     cfg_data,
    // access stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cbm_pkg::S_TDATA_W-1:0]      s_tdata,  // [15:0] bus_addr, [23:16] wdata
    input  logic [cbm_pkg::S_TUSER_W-1:0]      s_tuser,  // [1:0] mode, rest zero
    // translated address stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cbm_pkg::M_TDATA_W-1:0]      m_tdata,  // [18:0] mem_addr, rest zero
    output logic [cbm_pkg::M_TUSER_W-1:0]      m_tuser   // [1:0] target, rest zero
);

    localparam int PRG_SPAN_W = cbm_pkg::MEM_ADDR_W + 1;
    localparam int CHR_ADDR_W = 17;
    localparam int CHR_SPAN_W = CHR_ADDR_W + 1;

    // Configuration registers
    logic [cbm_pkg::VARIANT_W-1:0]   variant_reg;
    logic [cbm_pkg::SIZE_LOG2_W-1:0] prg_log2_reg;
    logic [cbm_pkg::SIZE_LOG2_W-1:0] chr_log2_reg;

    // Mapper state
    logic [cbm_pkg::SELECT_W-1:0]    select_reg;
    logic [cbm_pkg::BANK_W-1:0]      bank_reg [cbm_pkg::BANK_REGS];
    logic                            page_reg;

    // Input register
    logic                              in_valid_reg;
    logic [cbm_pkg::MODE_W-1:0]        in_mode_reg;
    logic [cbm_pkg::BUS_ADDR_W-1:0]    in_addr_reg;
    logic [cbm_pkg::WDATA_W-1:0]       in_wdata_reg;

    // Result register
    logic                              out_valid_reg;
    logic [cbm_pkg::TARGET_W-1:0]      out_target_reg;
    logic [cbm_pkg::MEM_ADDR_W-1:0]    out_addr_reg;

    // Translation signals
    logic                              out_load;
    logic                              advance;
    logic                              res_valid_next;
    logic [cbm_pkg::TARGET_W-1:0]      res_target_next;
    logic [cbm_pkg::MEM_ADDR_W-1:0]    res_addr_next;
    logic [cbm_pkg::BANK_IDX_W-1:0]    bank_idx;
    logic [cbm_pkg::BANK_W-1:0]        bank_sel;
    logic [cbm_pkg::SIZE_LOG2_W-1:0]   prg_log2;
    logic [cbm_pkg::SIZE_LOG2_W-1:0]   chr_log2;
    logic [PRG_SPAN_W-1:0]             prg_span;
    logic [PRG_SPAN_W-1:0]             prg_off;
    logic [CHR_SPAN_W-1:0]             chr_span;
    logic [CHR_ADDR_W-1:0]             chr_raw;
    logic                              is_write_range;
    logic                              page_bit;

    // Handshake: the input register moves on whenever the result register
    // can take a word
    assign out_load  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_load;
    assign s_tready  = !in_valid_reg || out_load;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            variant_reg  <= cbm_pkg::VAR_BASE;
            prg_log2_reg <= cbm_pkg::PRG_LOG2_RESET;
            chr_log2_reg <= cbm_pkg::CHR_LOG2_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                cbm_pkg::CFG_VARIANT:  variant_reg  <= cfg_data[cbm_pkg::VARIANT_W-1:0];
                cbm_pkg::CFG_PRG_SIZE: prg_log2_reg <= cfg_data;
                cbm_pkg::CFG_CHR_SIZE: chr_log2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_mode_reg  <= s_tuser[cbm_pkg::MODE_W-1:0];
            in_addr_reg  <= s_tdata[cbm_pkg::BUS_ADDR_W-1:0];
            in_wdata_reg <= s_tdata[cbm_pkg::BUS_ADDR_W +: cbm_pkg::WDATA_W];
        end
    end

    // Bank register index for the access in the input register
    always_comb begin
        case (in_mode_reg)
            cbm_pkg::MODE_PRG: begin
                bank_idx = in_addr_reg[13] ? 3'd7 : 3'd6;
            end
            cbm_pkg::MODE_CHR: begin
                if (variant_reg == cbm_pkg::VAR_A) begin
                    bank_idx = {1'b0, in_addr_reg[12:11]} + 3'd2;
                end else if (!in_addr_reg[12]) begin
                    bank_idx = {2'b00, in_addr_reg[11]};
                end else begin
                    bank_idx = in_addr_reg[12:10] - 3'd2;
                end
            end
            default: begin
                bank_idx = {2'b00, in_addr_reg[11]};
            end
        endcase
    end

    assign bank_sel = bank_reg[bank_idx];

    // Saturated sizes
    assign prg_log2 = cbm_pkg::clamp_log2(prg_log2_reg, cbm_pkg::PRG_LOG2_MIN,
                                          cbm_pkg::PRG_LOG2_MAX);
    assign chr_log2 = cbm_pkg::clamp_log2(chr_log2_reg, cbm_pkg::CHR_LOG2_MIN,
                                          cbm_pkg::CHR_LOG2_MAX);
    assign prg_span = PRG_SPAN_W'(1) << prg_log2;
    assign chr_span = CHR_SPAN_W'(1) << chr_log2;

    // Program window offset
    always_comb begin
        case (in_addr_reg[15:13])
            3'b100:  prg_off = {1'b0, bank_sel, 13'd0};
            3'b101:  prg_off = {1'b0, bank_sel, 13'd0};
            3'b110:  prg_off = prg_span - PRG_SPAN_W'(16'h4000);
            3'b111:  prg_off = prg_span - PRG_SPAN_W'(16'h2000);
            default: prg_off = '0;
        endcase
    end

    // Character address before size masking
    always_comb begin
        if (variant_reg == cbm_pkg::VAR_A) begin
            chr_raw = {bank_sel, in_addr_reg[10:0]};
        end else if (!in_addr_reg[12]) begin
            chr_raw = {1'b0, bank_sel[5:1], in_addr_reg[10:0]};
        end else begin
            chr_raw = {1'b1, bank_sel, in_addr_reg[9:0]};
        end
    end

    // Nametable page: bank bit 5 in variant B, latched page in variant C
    assign page_bit = (variant_reg == cbm_pkg::VAR_C) ? page_reg : bank_sel[5];

    // Result of the access
    always_comb begin
        res_valid_next  = 1'b0;
        res_target_next = cbm_pkg::TGT_PRG;
        res_addr_next   = '0;
        case (in_mode_reg)
            cbm_pkg::MODE_PRG: begin
                res_valid_next  = 1'b1;
                res_target_next = cbm_pkg::TGT_PRG;
                res_addr_next   = cbm_pkg::MEM_ADDR_W'(
                    ({7'd0, in_addr_reg[12:0]} | prg_off) & (prg_span - PRG_SPAN_W'(1)));
            end
            cbm_pkg::MODE_CHR: begin
                res_valid_next  = 1'b1;
                res_target_next = cbm_pkg::TGT_CHR;
                res_addr_next   = cbm_pkg::MEM_ADDR_W'(
                    {1'b0, chr_raw} & (chr_span - CHR_SPAN_W'(1)));
            end
            cbm_pkg::MODE_NT: begin
                res_valid_next  = (variant_reg == cbm_pkg::VAR_B) ||
                                  (variant_reg == cbm_pkg::VAR_C);
                res_target_next = cbm_pkg::TGT_NT;
                res_addr_next   = {8'd0, page_bit, in_addr_reg[9:0]};
            end
            default: ;
        endcase
    end

    // Mapper state update as a write leaves the input register
    assign is_write_range = advance && (in_mode_reg == cbm_pkg::MODE_WRITE) &&
                            in_addr_reg[15];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            select_reg <= '0;
            page_reg   <= 1'b0;
            for (int i = 0; i < cbm_pkg::BANK_REGS; i++) begin
                bank_reg[i] <= '0;
            end
        end else if (is_write_range) begin
            if (in_addr_reg[14:13] == 2'b00) begin
                if (in_addr_reg[0]) begin
                    bank_reg[select_reg] <= in_wdata_reg[cbm_pkg::BANK_W-1:0];
                end else begin
                    select_reg <= in_wdata_reg[cbm_pkg::SELECT_W-1:0];
                end
            end
            if (variant_reg == cbm_pkg::VAR_C) begin
                page_reg <= in_wdata_reg[6];
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= advance && res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && advance && res_valid_next) begin
            out_target_reg <= res_target_next;
            out_addr_reg   <= res_addr_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_addr_reg};
    assign m_tuser  = {6'd0, out_target_reg};

endmodule

// ===== test/bank_map_checker.sv =====
// ----------------------------------------------------------------------------
// bank_map_checker
// Watches the configuration, access and translated address channels of the
// cartridge bank mapper, predicts each translated address from its own copy
// of the bank registers and size settings, and compares every word that the
// block hands out with the oldest prediction.
// ----------------------------------------------------------------------------
module bank_map_checker
    import cbm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [15:0] bus_addr, [23:16] wdata
    input  logic [S_TUSER_W-1:0]   s_tuser,   // [1:0] mode, rest zero
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,   // [18:0] mem_addr, rest zero
    input  logic [M_TUSER_W-1:0]   m_tuser,   // [1:0] target, rest zero
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Register decode on the cpu bus
    localparam logic [BUS_ADDR_W-1:0] REG_DECODE_MASK = 16'he001;
    localparam logic [BUS_ADDR_W-1:0] REG_SELECT_ADDR = 16'h8000;
    localparam logic [BUS_ADDR_W-1:0] REG_BANK_ADDR   = 16'h8001;

    // Program windows, by cpu address bits 15..13
    localparam logic [2:0] WIN_SWITCH_LO = 3'd4;
    localparam logic [2:0] WIN_SWITCH_HI = 3'd5;
    localparam logic [2:0] WIN_FIXED_LO  = 3'd6;
    localparam logic [2:0] WIN_FIXED_HI  = 3'd7;
    localparam int         PRG_LO_REG    = 6;
    localparam int         PRG_HI_REG    = 7;
    localparam int unsigned FIXED_LO_BACK = 32'h4000;
    localparam int unsigned FIXED_HI_BACK = 32'h2000;

    // Character windows
    localparam logic [BANK_IDX_W-1:0] CHR_2K_REG_BASE = 3'd2;

    typedef struct packed {
        target_t               target;
        logic [MEM_ADDR_W-1:0] mem_addr;
    } mapped_addr_t;

    // Shadow configuration and bank state
    logic [VARIANT_W-1:0]   variant;
    logic [SIZE_LOG2_W-1:0] prg_log2;
    logic [SIZE_LOG2_W-1:0] chr_log2;
    logic [SELECT_W-1:0]    reg_select;
    logic [BANK_W-1:0]      banks [BANK_REGS];
    logic                   page_latch;

    mapped_addr_t expected_words [$];
    mapped_addr_t want;
    mapped_addr_t fresh;
    int           errors = 0;

    function automatic logic [SIZE_LOG2_W-1:0] saturate_log2(
        input logic [SIZE_LOG2_W-1:0] v,
        input logic [SIZE_LOG2_W-1:0] lo,
        input logic [SIZE_LOG2_W-1:0] hi
    );
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Applies one access to the shadow state; returns 1 when it gives a word
    function automatic bit translate_access(
        input  mode_t                 mode,
        input  logic [BUS_ADDR_W-1:0] addr,
        input  logic [WDATA_W-1:0]    data,
        output mapped_addr_t          word
    );
        int unsigned size;
        int unsigned off;
        int unsigned res;
        logic [2:0]  slot;
        logic        page;
        word = '0;
        off  = 0;
        res  = 0;
        case (mode)
            MODE_WRITE: begin
                // only the upper half of the cpu bus reaches the registers
                if (addr[15]) begin
                    if ((addr & REG_DECODE_MASK) == REG_SELECT_ADDR) begin
                        reg_select = data[SELECT_W-1:0];
                    end else if ((addr & REG_DECODE_MASK) == REG_BANK_ADDR) begin
                        banks[reg_select] = data[BANK_W-1:0];
                    end
                    if (variant == VAR_C) begin
                        page_latch = data[6];
                    end
                end
                return 1'b0;
            end
            MODE_PRG: begin
                size = 32'd1 << saturate_log2(prg_log2, PRG_LOG2_MIN, PRG_LOG2_MAX);
                case (addr[15:13])
                    WIN_SWITCH_LO: off = 32'({banks[PRG_LO_REG], 13'b0});
                    WIN_SWITCH_HI: off = 32'({banks[PRG_HI_REG], 13'b0});
                    WIN_FIXED_LO:  off = size - FIXED_LO_BACK;
                    WIN_FIXED_HI:  off = size - FIXED_HI_BACK;
                    default:       off = 0;
                endcase
                word.target = TGT_PRG;
                res = ({19'b0, addr[12:0]} | off) & (size - 1);
            end
            MODE_CHR: begin
                size = 32'd1 << saturate_log2(chr_log2, CHR_LOG2_MIN, CHR_LOG2_MAX);
                slot = addr[12:10];
                if (variant == VAR_A) begin
                    // four 2 KB windows from registers 2..5
                    off = 32'({banks[CHR_2K_REG_BASE + {1'b0, addr[12:11]}], 11'b0});
                    res = 32'(addr[10:0]) | off;
                end else if (!slot[2]) begin
                    // 2 KB windows, low bank bit ignored
                    off = 32'({banks[slot >> 1][BANK_W-1:1], 11'b0});
                    res = 32'(addr[10:0]) | off;
                end else begin
                    // 1 KB windows with A16 forced high
                    off = 32'({1'b1, banks[slot - 3'd2], 10'b0});
                    res = 32'(addr[9:0]) | off;
                end
                word.target = TGT_CHR;
                res = res & (size - 1);
            end
            default: begin
                if (variant == VAR_B) begin
                    page = banks[addr[11]][5];
                end else if (variant == VAR_C) begin
                    page = page_latch;
                end else begin
                    // mirroring is board wiring in these variants
                    return 1'b0;
                end
                word.target = TGT_NT;
                res = 32'({page, addr[9:0]});
            end
        endcase
        word.mem_addr = res[MEM_ADDR_W-1:0];
        return 1'b1;
    endfunction

    // Compare outgoing words first, then predict the incoming one
    always @(posedge aclk) begin
        if (!aresetn) begin
            variant    = VAR_BASE;
            prg_log2   = PRG_LOG2_RESET;
            chr_log2   = CHR_LOG2_RESET;
            reg_select = '0;
            page_latch = 1'b0;
            foreach (banks[i]) banks[i] = '0;
            expected_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_VARIANT:  variant  = cfg_data[VARIANT_W-1:0];
                    CFG_PRG_SIZE: prg_log2 = cfg_data;
                    CFG_CHR_SIZE: chr_log2 = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, got tuser %h tdata %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = expected_words.pop_front();
                    if (m_tuser !== M_TUSER_W'(want.target)) begin
                        errors++;
                        $display("%0t: target mismatch, expected %h got %h",
                                 $time, M_TUSER_W'(want.target), m_tuser);
                    end
                    if (m_tdata !== M_TDATA_W'(want.mem_addr)) begin
                        errors++;
                        $display("%0t: mem_addr mismatch, expected %h got %h",
                                 $time, M_TDATA_W'(want.mem_addr), m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (translate_access(mode_t'(s_tuser[MODE_W-1:0]),
                                     s_tdata[BUS_ADDR_W-1:0],
                                     s_tdata[BUS_ADDR_W +: WDATA_W], fresh)) begin
                    expected_words.push_back(fresh);
                end
            end
        end
        pending    <= expected_words.size();
        fail_count <= errors;
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives bus accesses and size/variant settings into the cartridge bank
// mapper with random idle and back-pressure, while a checker alongside
// predicts and compares every translated address word.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cbm_pkg::*;

    localparam int PHASES           = 9;
    localparam int RANDOM_PER_PHASE = 103;
    localparam int SETTLE_CYCLES    = 6;     // input and result registers plus margin
    localparam int WATCHDOG_LIMIT   = 1000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;   // [15:0] bus_addr, [23:16] wdata
    logic [S_TUSER_W-1:0]   s_tuser   = '0;   // [1:0] mode, rest zero
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;          // [18:0] mem_addr, rest zero
    logic [M_TUSER_W-1:0]   m_tuser;          // [1:0] target, rest zero

    int fail_count;
    int pending;
    int idle_cycles    = 0;
    int stall_left     = 0;
    int rx_stall       = 0;
    int taken_words    = 0;
    bit receiver_calm  = 1'b0;
    bit sender_calm    = 1'b0;

    // Settings per phase; phase 0 runs on the reset values
    variant_t               phase_variant [PHASES] =
        '{VAR_BASE, VAR_BASE, VAR_A, VAR_B, VAR_C, VAR_B, VAR_C, VAR_A, VAR_BASE};
    logic [SIZE_LOG2_W-1:0] phase_prg [PHASES] =
        '{5'd17, 5'd14, 5'd19, 5'd0, 5'd16, 5'd17, 5'd31, 5'd18, 5'd15};
    logic [SIZE_LOG2_W-1:0] phase_chr [PHASES] =
        '{5'd17, 5'd13, 5'd17, 5'd31, 5'd15, 5'd14, 5'd0, 5'd16, 5'd31};

    cartridge_bank_mapper u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    bank_map_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver: random stall after each word, calm spells with none
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else if (m_tvalid && m_tready) begin
            if (taken_words % 32 == 0) begin
                receiver_calm = ($urandom_range(0, 2) == 0);
            end
            taken_words++;
            rx_stall = receiver_calm ? 0 : $urandom_range(0, 19);
            stall_left <= rx_stall;
            m_tready   <= (rx_stall == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: cycles with no word moving on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One access word; valid stays high into the next word when there is no gap
    task automatic send_access(
        input mode_t                 mode,
        input logic [BUS_ADDR_W-1:0] addr,
        input logic [WDATA_W-1:0]    data
    );
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {data, addr};
        s_tuser  <= S_TUSER_W'(mode);
        do @(posedge aclk); while (!s_tready);
    endtask

    // Register write; valid is dropped by the caller after the last one
    task automatic cfg_write(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_setting(
        input variant_t               v,
        input logic [SIZE_LOG2_W-1:0] prg,
        input logic [SIZE_LOG2_W-1:0] chr,
        input bit                     touch_spare
    );
        cfg_write(CFG_VARIANT, CFG_DATA_W'(v));
        cfg_write(CFG_PRG_SIZE, prg);
        cfg_write(CFG_CHR_SIZE, chr);
        if (touch_spare) begin
            cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every predicted word is out, then let the pipe empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly well-formed select/bank writes and reads, some stray writes
    task automatic random_access();
        int                    pick;
        logic [BUS_ADDR_W-1:0] addr;
        logic [WDATA_W-1:0]    data;
        pick = $urandom_range(0, 99);
        addr = BUS_ADDR_W'($urandom);
        data = WDATA_W'($urandom);
        if (pick < 12) begin
            send_access(MODE_WRITE, {3'b100, addr[12:1], 1'b0}, data);
        end else if (pick < 24) begin
            send_access(MODE_WRITE, {3'b100, addr[12:1], 1'b1}, data);
        end else if (pick < 30) begin
            send_access(MODE_WRITE, addr, data);
        end else if (pick < 55) begin
            send_access(MODE_PRG, addr, data);
        end else if (pick < 80) begin
            send_access(MODE_CHR, addr, data);
        end else begin
            send_access(MODE_NT, addr, data);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: bank loads, decode edges, window edges
        sender_calm = 1'b0;
        send_access(MODE_WRITE, 16'h8000, 8'h00);
        send_access(MODE_WRITE, 16'h8001, 8'hff);   // bank 0 all ones
        send_access(MODE_WRITE, 16'h8000, 8'h07);
        send_access(MODE_WRITE, 16'h9fff, 8'h3f);   // mirrored bank port
        send_access(MODE_WRITE, 16'h8000, 8'h06);
        send_access(MODE_WRITE, 16'h8001, 8'h2a);
        send_access(MODE_WRITE, 16'h8000, 8'h02);
        send_access(MODE_WRITE, 16'h8001, 8'h15);
        send_access(MODE_WRITE, 16'ha001, 8'h00);   // in range, loads nothing
        send_access(MODE_WRITE, 16'h7fff, 8'hff);   // below register range
        send_access(MODE_WRITE, 16'hffff, 8'h55);
        send_access(MODE_PRG, 16'h0000, 8'h00);
        send_access(MODE_PRG, 16'h7fff, 8'hff);     // below the windows
        send_access(MODE_PRG, 16'h8000, 8'h00);
        send_access(MODE_PRG, 16'hbfff, 8'hff);
        send_access(MODE_PRG, 16'hc000, 8'h00);
        send_access(MODE_PRG, 16'hffff, 8'hff);
        send_access(MODE_CHR, 16'h0000, 8'h00);
        send_access(MODE_CHR, 16'h0fff, 8'hff);
        send_access(MODE_CHR, 16'h1000, 8'h00);
        send_access(MODE_CHR, 16'h1fff, 8'hff);
        send_access(MODE_CHR, 16'hffff, 8'h00);     // high bits ignored
        send_access(MODE_NT, 16'h2000, 8'h00);      // no word in base variant
        send_access(MODE_NT, 16'hffff, 8'hff);

        // Random phases across variants and size extremes
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                drain_results();
                apply_setting(phase_variant[ph], phase_prg[ph], phase_chr[ph], ph == 3);
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 16 == 0) begin
                    sender_calm = ($urandom_range(0, 3) == 0);
                end
                if (ph == 4 && n == RANDOM_PER_PHASE / 2) begin
                    drain_results();
                end
                random_access();
            end
        end

        drain_results();
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
